/* src/assert_macros.svh */
// Assertion macros for the RTL folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("check failed");
`define CHK_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("check failed");
`else
`define CHK_IMPLY(label, clk, rst, pre, post)
`define CHK_NEXT(label, clk, rst, pre, post)
`endif
`endif

/* src/rhg_pkg.sv */
// ----------------------------------------------------------------------------
// rhg_pkg
// Types and constants shared by the hue gate cells.
// ----------------------------------------------------------------------------
`default_nettype none
package rhg_pkg;
   localparam int QUOT_W = 17;
   localparam logic [15:0] TARGET_RESET = 16'd10925;
   localparam logic [15:0] TOL_RESET    = 16'd6554;
   localparam logic CSR_TARGET = 1'b0;
   localparam logic CSR_TOL    = 1'b1;

   // word carried from cell to cell
   typedef struct packed {
      logic        valid;
      logic        fin;
      logic        grey;
      logic [16:0] light;
      logic [11:0] hden;      // 12*d
      logic [28:0] hrem;      // hue dividend remainder
      logic [16:0] hquo;
      logic [8:0]  sden;      // 2*den, up to 510
      logic [24:0] srem;      // d*131070 + den, up to 25 bits
      logic [16:0] squo;
   } cell_word_type;
endpackage
`default_nettype wire

/* src/rgb_hsl_hue_gate.sv */
// ----------------------------------------------------------------------------
// rgb_hsl_hue_gate
// RGB to HSL conversion with a relative hue band gate.
// ----------------------------------------------------------------------------
// Takes one word per clock while not stalled. Stages: one setup stage, a
// chain of 17 division cells (one quotient bit of hue and saturation per
// cell), a multiply stage and the output register. The whole chain stalls
// together when rsp_stall holds a valid result.
`default_nettype none
`include "assert_macros.svh"
module rgb_hsl_hue_gate (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_red,
   input  wire logic [7:0]  req_green,
   input  wire logic [7:0]  req_blue,
   input  wire logic        req_coords_finite,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_keep,
   output logic [15:0]      rsp_hue,
   output logic [15:0]      rsp_saturation,
   output logic [15:0]      rsp_lightness,
   input  wire logic        csr_write,
   input  wire logic [0:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   localparam int NC = rhg_pkg::QUOT_W;

   logic [15:0] target_ff, tol_ff;
   logic        advance;
   rhg_pkg::cell_word_type chain [0:NC];
   rhg_pkg::cell_word_type head_in;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= rhg_pkg::TARGET_RESET;
         tol_ff    <= rhg_pkg::TOL_RESET;
      end else if (csr_write) begin
         if (csr_index[0] == rhg_pkg::CSR_TARGET) target_ff <= csr_data;
         else tol_ff <= csr_data;
      end
   end

   // whole pipe moves unless a result is held
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // setup: max, min, numerators
   logic [7:0] mx, mn, d;
   logic [8:0] sum, den;
   logic [10:0] n;
   always_comb begin
      mx = req_red;
      if (req_green > mx) mx = req_green;
      if (req_blue > mx) mx = req_blue;
      mn = req_red;
      if (req_green < mn) mn = req_green;
      if (req_blue < mn) mn = req_blue;
      d = mx - mn;
      sum = {1'b0, mx} + {1'b0, mn};
      den = (sum < 9'd255) ? sum : 9'd510 - sum;
      if (req_red == mx) begin
         n = (req_green >= req_blue) ? {3'd0, req_green - req_blue}
            : 11'd6 * {3'd0, d} - ({3'd0, req_blue} - {3'd0, req_green});
      end else if (req_green == mx) begin
         n = 11'd2 * {3'd0, d} + {3'd0, req_blue} - {3'd0, req_red};
      end else begin
         n = 11'd4 * {3'd0, d} + {3'd0, req_red} - {3'd0, req_green};
      end
      head_in = '0;
      head_in.valid = req_valid;
      head_in.fin   = req_coords_finite;
      head_in.grey  = (d == 8'd0);
      head_in.light = 17'(({8'd0, sum} * 17'd257 + 17'd1) >> 1);
      head_in.hden  = 12'd12 * {4'd0, d};
      head_in.hrem  = {1'b0, n, 17'd0} + {17'd0, 12'd6 * {4'd0, d}};
      head_in.sden  = {den[7:0], 1'b0};
      head_in.srem  = {17'd0, d} * 25'd131070 + {16'd0, den};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain[0].valid <= 1'b0;
      end else if (advance) begin
         chain[0] <= head_in;
      end
   end

   // one cell per quotient bit, MSB first
   for (genvar i = 0; i < NC; i++) begin : g_cell
      rhg_div_cell #(.BIT(NC - 1 - i)) u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .word_in(chain[i]), .word_out(chain[i + 1])
      );
   end

   // multiply stage for band test
   rhg_pkg::cell_word_type tail;
   logic [15:0] hue_c, sat_c;
   logic [32:0] lo_c, hi_c;
   logic        mv_ff, mfin_ff;
   logic [15:0] mhue_ff, msat_ff, mlight_ff;
   logic [32:0] lo_ff, hi_ff;
   assign tail = chain[NC];
   always_comb begin
      hue_c = tail.grey ? 16'd0 : (tail.hquo[16] ? 16'hFFFF : tail.hquo[15:0]);
      sat_c = tail.grey ? 16'd0 : (tail.squo[16] ? 16'hFFFF : tail.squo[15:0]);
      lo_c = {17'd0, hue_c} * (33'd65536 - {17'd0, tol_ff});
      hi_c = {17'd0, hue_c} * (33'd65536 + {17'd0, tol_ff});
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= 1'b0;
      end else if (advance) begin
         mv_ff <= tail.valid;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         mfin_ff <= tail.fin; mhue_ff <= hue_c; msat_ff <= sat_c;
         mlight_ff <= tail.light[15:0]; lo_ff <= lo_c; hi_ff <= hi_c;
      end
   end

   // output register
   logic [32:0] t_c;
   logic rv_ff;
   assign t_c = {1'b0, target_ff, 16'd0};
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (advance) begin
         rv_ff <= mv_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_keep <= mfin_ff && (lo_ff < t_c) && (t_c < hi_ff);
         rsp_hue <= mhue_ff; rsp_saturation <= msat_ff; rsp_lightness <= mlight_ff;
      end
   end
   assign rsp_valid = rv_ff;

   `CHK_IMPLY(a_stall_hold, clock, reset, rsp_valid && rsp_stall, req_stall)
   `CHK_NEXT(a_out_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_hue))
   `CHK_IMPLY(a_keep_hue, clock, reset, rsp_valid && rsp_keep, rsp_hue != 16'd0)
endmodule
`default_nettype wire

/* src/rhg_div_cell.sv */
// ----------------------------------------------------------------------------
// rhg_div_cell
// One restoring-division cell: yields one quotient bit of hue and of
// saturation and hands the word to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none
module rhg_div_cell #(
   parameter int BIT = 0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire rhg_pkg::cell_word_type word_in,
   output rhg_pkg::cell_word_type     word_out
);
   rhg_pkg::cell_word_type word_ff, word_in_n;
   logic [40:0] htrial;
   logic [33:0] strial;

   // compare divisor shifted to this bit position
   always_comb begin
      word_in_n = word_in;
      htrial = {word_in.hden, 29'd0} >> (29 - BIT);
      strial = {word_in.sden, 25'd0} >> (25 - BIT);
      if ({12'd0, word_in.hrem} >= htrial) begin
         word_in_n.hrem = word_in.hrem - htrial[28:0];
         word_in_n.hquo[BIT] = 1'b1;
      end
      if ({9'd0, word_in.srem} >= strial) begin
         word_in_n.srem = word_in.srem - strial[24:0];
         word_in_n.squo[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (advance) begin
         word_ff <= word_in_n;
      end
   end
   assign word_out = word_ff;
endmodule
`default_nettype wire

/* test/tb_rgb_hsl_hue_gate.sv */
// ----------------------------------------------------------------------------
// tb_rgb_hsl_hue_gate
// Self-checking bench for the RGB to HSL hue gate.
// ----------------------------------------------------------------------------
// Drives color words with random gaps, stalls the result side at random and
// compares every result word against an independent HSL and band predictor.
// The band registers are reprogrammed between phases while the pipe is empty.
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard: predicts HSL results and checks them in order
class hsl_scoreboard;
   typedef struct packed {
      logic        keep;
      logic [15:0] hue;
      logic [15:0] sat;
      logic [15:0] light;
   } hsl_word_type;

   logic [15:0]  target_hue;
   logic [15:0]  tolerance;
   hsl_word_type pending[$];
   int           errors;

   function new();
      target_hue = rhg_pkg::TARGET_RESET;
      tolerance  = rhg_pkg::TOL_RESET;
      errors     = 0;
   endfunction

   function hsl_word_type convert(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fin);
      hsl_word_type w;
      logic [8:0]   mx, mn, d, sum, den;
      logic [63:0]  s, h, n, lo, hi, t;
      mx = (r > g) ? r : g;
      if (b > mx) mx = b;
      mn = (r < g) ? r : g;
      if (b < mn) mn = b;
      d = mx - mn;
      sum = mx + mn;
      w.light = 16'((32'(sum) * 257 + 1) / 2);
      w.hue = 0;
      w.sat = 0;
      if (d != 0) begin
         den = (sum < 255) ? sum : 9'(510 - sum);
         s = (64'(d) * 131070 + den) / (2 * 64'(den));
         w.sat = (s > 65535) ? 16'hFFFF : s[15:0];
         // sextant numerator, ties to red then green
         if (r == mx)
            n = (g >= b) ? 64'(g - b) : 6 * 64'(d) - 64'(b - g);
         else if (g == mx)
            n = 2 * 64'(d) + b - r;
         else
            n = 4 * 64'(d) + r - g;
         h = (n * 131072 + 6 * 64'(d)) / (12 * 64'(d));
         w.hue = (h > 65535) ? 16'hFFFF : h[15:0];
      end
      lo = 64'(w.hue) * (65536 - 64'(tolerance));
      hi = 64'(w.hue) * (65536 + 64'(tolerance));
      t  = 64'(target_hue) * 65536;
      w.keep = fin && lo < t && t < hi;
      return w;
   endfunction

   function void note_point(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fin);
      pending.push_back(convert(r, g, b, fin));
   endfunction

   function void check_result(logic keep, logic [15:0] hue, logic [15:0] sat,
                              logic [15:0] light);
      hsl_word_type e;
      if (pending.size() == 0) begin
         $error("unexpected result word");
         errors++;
         return;
      end
      e = pending.pop_front();
      if (keep !== e.keep) begin
         $error("keep: expected %0d, got %0d", e.keep, keep); errors++;
      end
      if (hue !== e.hue) begin
         $error("hue: expected %0d, got %0d", e.hue, hue); errors++;
      end
      if (sat !== e.sat) begin
         $error("saturation: expected %0d, got %0d", e.sat, sat); errors++;
      end
      if (light !== e.light) begin
         $error("lightness: expected %0d, got %0d", e.light, light); errors++;
      end
   endfunction
endclass

module tb_rgb_hsl_hue_gate;
   localparam int LATENCY   = 20;
   localparam int MAX_CYCLE = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_red = '0, req_green = '0, req_blue = '0;
   logic        req_coords_finite = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_keep;
   logic [15:0] rsp_hue, rsp_saturation, rsp_lightness;
   logic        csr_write = 1'b0;
   logic [0:0]  csr_index = rhg_pkg::CSR_TARGET;
   logic [15:0] csr_data = '0;

   hsl_scoreboard sb = new();
   int  cycle = 0;
   bit  hold_rsp = 0;      // long receiver hold-off request

   rgb_hsl_hue_gate DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // cycle limit
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > MAX_CYCLE) begin
         $display("FAIL rgb_hsl_hue_gate");
         $finish;
      end
   end

   // result monitor
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_keep, rsp_hue, rsp_saturation, rsp_lightness);

   // receiver stall pattern
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (80) @(negedge clock);
            hold_rsp = 0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
         if ($urandom_range(0, 1)) gap = 0;
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(negedge clock);
      end
   end

   // send one word; valid stays up until the next call or a drain
   task automatic send_point(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fin,
                             int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_red <= r; req_green <= g; req_blue <= b;
      req_coords_finite <= fin;
      do @(posedge clock); while (req_stall);
      sb.note_point(r, g, b, fin);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [15:0] val);
      csr_write <= 1'b1; csr_index <= idx; csr_data <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == rhg_pkg::CSR_TARGET) sb.target_hue = val; else sb.tolerance = val;
   endtask

   task automatic random_burst(int count);
      int gap;
      logic [7:0] r, g, b;
      for (int i = 0; i < count; i++) begin
         r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
         case ($urandom_range(0, 5))
            0: g = r;                // red/green tie
            1: b = r;                // red/blue tie
            2: begin g = r; b = r; end  // grey
            default: ;
         endcase
         gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 14) : 0;
         if ((i / 40) % 3 == 2) gap = 0;
         send_point(r, g, b, $urandom_range(0, 7) != 0, gap);
      end
   endtask

   initial begin
      logic [15:0] targets[5];
      logic [15:0] tols[5];
      targets = '{16'd0, 16'hFFFF, 16'd21845, 16'd10925, 16'd43690};
      tols    = '{16'hFFFF, 16'd0, 16'd6554, 16'd1, 16'd32768};
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes, ties, greys, sextants, non-finite
      send_point(0, 0, 0, 1, 0);
      send_point(255, 255, 255, 1, 0);
      send_point(255, 0, 0, 1, 0);
      send_point(0, 255, 0, 1, 0);
      send_point(0, 0, 255, 1, 0);
      send_point(255, 255, 0, 1, 0);
      send_point(0, 255, 255, 1, 0);
      send_point(255, 0, 255, 1, 0);
      send_point(255, 0, 1, 1, 0);
      send_point(128, 128, 128, 0, 0);
      send_point(255, 128, 0, 1, 0);
      send_point(255, 128, 0, 0, 0);
      send_point(1, 0, 0, 1, 0);
      send_point(255, 254, 254, 1, 0);
      send_point(170, 85, 0, 1, 0);
      send_point(200, 100, 100, 1, 0);
      drain();

      // long receiver hold-off while sending continues
      hold_rsp = 1;
      random_burst(60);
      drain();

      for (int p = 0; p < 5; p++) begin
         write_reg(rhg_pkg::CSR_TARGET, targets[p]);
         write_reg(rhg_pkg::CSR_TOL, tols[p]);
         random_burst(260);
         drain();
      end

      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("PASS rgb_hsl_hue_gate");
      else
         $display("FAIL rgb_hsl_hue_gate");
      $finish;
   end
endmodule
`default_nettype wire

/* rgb_hsl_hue_gate.f */
+incdir+src
src/rhg_pkg.sv
src/rhg_div_cell.sv
src/rgb_hsl_hue_gate.sv
test/tb_rgb_hsl_hue_gate.sv
